// File: rtl/touch_event_calibrator_core_defines.svh
// assertion macros shared by the checker files of the touch event calibrator
// no dependencies; take in with a bare include inside a module body
`ifndef TOUCH_EVENT_CALIBRATOR_CORE_DEFINES_SVH
`define TOUCH_EVENT_CALIBRATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled by the given condition
`define TEC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tec_pkg.sv
// shared types, constants and codes of the touch event calibrator
// no dependencies; used by every module of the block
package tec_pkg;

  localparam int RAW_BITS  = 16;
  localparam int POS_BITS  = 12;
  localparam int TYPE_BITS = 16;
  localparam int CODE_BITS = 16;
  localparam int PRES_BITS = 16;

  localparam logic [TYPE_BITS-1:0] TYPE_KEY      = TYPE_BITS'(1);
  localparam logic [TYPE_BITS-1:0] TYPE_ABS      = TYPE_BITS'(3);
  localparam logic [CODE_BITS-1:0] CODE_X        = CODE_BITS'(16'h0000);
  localparam logic [CODE_BITS-1:0] CODE_Y        = CODE_BITS'(16'h0001);
  localparam logic [CODE_BITS-1:0] CODE_PRESSURE = CODE_BITS'(16'h0018);
  localparam logic [CODE_BITS-1:0] CODE_TOUCH    = CODE_BITS'(16'h014a);

  localparam logic [PRES_BITS-1:0] PRES_KEY_DOWN = PRES_BITS'(255);
  localparam logic [PRES_BITS-1:0] PRES_KEY_UP   = '0;

  // calibration arithmetic widths
  localparam int OFFS_W = RAW_BITS + 1;      // raw - low, signed
  localparam int FAC_W  = POS_BITS + 1;      // res - trim, signed
  localparam int PROD_W = OFFS_W + FAC_W;    // signed product
  localparam int MAG_W  = PROD_W - 1;        // product magnitude
  localparam int V_W    = PROD_W + 1;        // quotient plus margin, signed
  localparam int CNT_BITS = $clog2(MAG_W);

  localparam logic signed [FAC_W-1:0] FACTOR_TRIM = FAC_W'(30);
  localparam logic [V_W-1:0]          POS_MARGIN  = V_W'(15);

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (RAW_BITS > POS_BITS) ? RAW_BITS : POS_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_X_LOW  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_X_HIGH = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_LOW  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_HIGH = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = CFG_IDX_BITS'(4);
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = CFG_IDX_BITS'(5);
  localparam logic [CFG_IDX_BITS-1:0] REG_SWAP   = CFG_IDX_BITS'(6);

  // command queue between classifier and back end, power of two depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [TYPE_BITS-1:0] event_type;
    logic [CODE_BITS-1:0] event_code;
    logic [RAW_BITS-1:0]  event_value;
  } evt_word_t;

  typedef struct packed {
    logic [POS_BITS-1:0]  pos_x;
    logic [POS_BITS-1:0]  pos_y;
    logic [PRES_BITS-1:0] pressure;
  } smp_word_t;

  typedef enum logic [1:0] {
    OP_X      = 2'd0,
    OP_Y      = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [RAW_BITS-1:0]  value;
    logic [PRES_BITS-1:0] pres;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

  typedef struct packed {
    logic [RAW_BITS-1:0] x_low;
    logic [RAW_BITS-1:0] x_high;
    logic [RAW_BITS-1:0] y_low;
    logic [RAW_BITS-1:0] y_high;
    logic [POS_BITS-1:0] width;
    logic [POS_BITS-1:0] height;
    logic                swap;
  } cfg_t;

endpackage

// File: rtl/tec_front.sv
// front end: takes event words, sorts them into axis and sample commands
// depends on tec_pkg; feeds tec_queue
module tec_front (
  input  tec_pkg::evt_word_t evt,
  input  logic               evt_valid,
  output logic               evt_stall,
  input  tec_pkg::q_stat_t   qstat,
  output logic               push,
  output tec_pkg::cmd_t      cmd
);
  import tec_pkg::*;

  logic is_x;
  logic is_y;
  logic is_pres;
  logic is_key;

  assign is_x    = (evt.event_type == TYPE_ABS) && (evt.event_code == CODE_X);
  assign is_y    = (evt.event_type == TYPE_ABS) && (evt.event_code == CODE_Y);
  assign is_pres = (evt.event_type == TYPE_ABS) && (evt.event_code == CODE_PRESSURE);
  assign is_key  = (evt.event_type == TYPE_KEY) && (evt.event_code == CODE_TOUCH);

  assign evt_stall = qstat.full;

  // unknown words are taken and dropped here
  assign push = evt_valid && !qstat.full && (is_x || is_y || is_pres || is_key);

  always_comb begin
    cmd.value = evt.event_value;
    if (is_x) begin
      cmd.op = OP_X;
    end else if (is_y) begin
      cmd.op = OP_Y;
    end else begin
      cmd.op = OP_SAMPLE;
    end
    if (is_key) begin
      cmd.pres = (evt.event_value != '0) ? PRES_KEY_DOWN : PRES_KEY_UP;
    end else begin
      cmd.pres = PRES_BITS'(evt.event_value);
    end
  end

endmodule

// File: rtl/tec_queue.sv
// short command queue between front end and back end
// depends on tec_pkg
module tec_queue (
  input  logic             clk,
  input  logic             rst,
  input  tec_pkg::q_ctl_t  qctl,
  input  tec_pkg::cmd_t    wr_cmd,
  output tec_pkg::q_stat_t qstat,
  output tec_pkg::cmd_t    rd_cmd
);
  import tec_pkg::*;

  cmd_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign qstat.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign qstat.avail = (count != '0);
  assign do_push     = qctl.push && !qstat.full;
  assign do_pop      = qctl.pop && qstat.avail;
  assign rd_cmd      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/tec_back.sv
// back end: scales axis readings with a serial divider, holds the last
// position and emits samples through an output register; depends on tec_pkg
module tec_back (
  input  logic                clk,
  input  logic                rst,
  input  tec_pkg::cfg_t       cfg,
  input  tec_pkg::cmd_t       cmd,
  input  tec_pkg::q_stat_t    qstat,
  output logic                pop,
  output logic                smp_valid,
  input  logic                smp_stall,
  output tec_pkg::smp_word_t  smp
);
  import tec_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_ABS  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_ADJ  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic                       axis_y;
  logic signed [OFFS_W-1:0]   offs;
  logic signed [OFFS_W-1:0]   span;
  logic signed [FAC_W-1:0]    factor;
  logic [POS_BITS-1:0]        res;
  logic signed [PROD_W-1:0]   prod;
  logic                       neg;
  logic [RAW_BITS-1:0]        dvs;
  logic [RAW_BITS:0]          rem;
  logic [MAG_W-1:0]           quo;
  logic [CNT_BITS-1:0]        cnt;
  logic signed [V_W-1:0]      v;
  logic [POS_BITS-1:0]        last_x;
  logic [POS_BITS-1:0]        last_y;
  logic                       x_seen;
  logic                       y_seen;

  logic                       out_free;
  logic                       load_smp;
  logic [RAW_BITS-1:0]        sel_low;
  logic [RAW_BITS-1:0]        sel_high;
  logic [POS_BITS-1:0]        sel_res;
  logic [PROD_W-1:0]          prod_mag;
  logic [OFFS_W-1:0]          span_mag;
  logic [RAW_BITS:0]          rem_sh;
  logic [RAW_BITS+1:0]        diff;
  logic signed [V_W-1:0]      res_ext;
  logic [POS_BITS-1:0]        v_clamp;

  assign out_free = !smp_valid || !smp_stall;
  assign sel_low  = (cmd.op == OP_Y) ? cfg.y_low  : cfg.x_low;
  assign sel_high = (cmd.op == OP_Y) ? cfg.y_high : cfg.x_high;
  assign sel_res  = (cmd.op == OP_Y) ? cfg.height : cfg.width;
  assign prod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign span_mag = span[OFFS_W-1] ? OFFS_W'(-span) : OFFS_W'(span);
  assign rem_sh   = {rem[RAW_BITS-1:0], quo[MAG_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign res_ext  = signed'({{(V_W-POS_BITS){1'b0}}, res});

  always_comb begin
    if (v[V_W-1]) begin
      v_clamp = '0;
    end else if (v > res_ext) begin
      v_clamp = res;
    end else begin
      v_clamp = v[POS_BITS-1:0];
    end
  end

  always_comb begin
    pop        = 1'b0;
    load_smp   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (qstat.avail) begin
          case (cmd.op)
            OP_X, OP_Y: begin
              pop        = 1'b1;
              state_next = ST_MUL;
            end
            OP_SAMPLE: begin
              // a sample waits until the output register can take it
              pop      = out_free;
              load_smp = out_free && x_seen && y_seen;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_MUL:  state_next = ST_ABS;
      ST_ABS:  state_next = (span == '0) ? ST_ADJ : ST_DIV;
      ST_DIV:  state_next = (cnt == CNT_BITS'(MAG_W - 1)) ? ST_ADJ : ST_DIV;
      ST_ADJ:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      x_seen    <= 1'b0;
      y_seen    <= 1'b0;
      last_x    <= '0;
      last_y    <= '0;
      smp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_smp) begin
        smp_valid <= 1'b1;
      end else if (!smp_stall) begin
        smp_valid <= 1'b0;
      end
      if (state == ST_FIN) begin
        if (axis_y) begin
          last_y <= res - v_clamp;
          y_seen <= 1'b1;
        end else begin
          last_x <= res - v_clamp;
          x_seen <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (load_smp) begin
      smp.pos_x    <= cfg.swap ? last_y : last_x;
      smp.pos_y    <= cfg.swap ? last_x : last_y;
      smp.pressure <= cmd.pres;
    end
    case (state)
      ST_IDLE: begin
        axis_y <= (cmd.op == OP_Y);
        offs   <= signed'({1'b0, cmd.value}) - signed'({1'b0, sel_low});
        span   <= signed'({1'b0, sel_high}) - signed'({1'b0, sel_low});
        factor <= signed'({1'b0, sel_res}) - FACTOR_TRIM;
        res    <= sel_res;
      end
      ST_MUL: begin
        prod <= offs * factor;
      end
      ST_ABS: begin
        neg <= prod[PROD_W-1] ^ span[OFFS_W-1];
        quo <= (span == '0) ? '0 : prod_mag[MAG_W-1:0];
        dvs <= span_mag[RAW_BITS-1:0];
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!diff[RAW_BITS+1]) begin
          rem <= diff[RAW_BITS:0];
          quo <= {quo[MAG_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[MAG_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
      end
      ST_ADJ: begin
        v <= neg ? signed'(POS_MARGIN - {2'b00, quo}) : signed'(POS_MARGIN + {2'b00, quo});
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/touch_event_calibrator_core.sv
// Touch event calibrator. Raw input event words (type, code, value) enter on the evt
// channel; absolute X and Y readings are mapped linearly between their calibration
// points onto the screen, clamped and mirrored, and kept as the last position. A
// pressure or touch key word emits one sample word (pos_x, pos_y, pressure) on the smp
// channel once both axes have been seen since reset; other words are dropped. An X or Y
// word keeps the back end busy for one multiply, 29 steps of the serial divider and the
// steps that take magnitudes, apply the sign and clamp; the divider steps are skipped
// when the calibration span is zero. A sample word is handled in the idle state. A
// two-entry queue lets the input side take words while the divider runs or a sample
// waits on a stalled output. Registers are written over the cfg port, which is always
// ready, and should only be changed while the block is idle.
// depends on tec_pkg, tec_front, tec_queue, tec_back
module touch_event_calibrator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                evt_valid,
  output logic                                evt_stall,
  input  tec_pkg::evt_word_t                  evt,
  output logic                                smp_valid,
  input  logic                                smp_stall,
  output tec_pkg::smp_word_t                  smp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tec_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tec_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tec_pkg::*;

  cfg_t    cfg;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  q_ctl_t  qctl;
  q_stat_t qstat;
  logic    push;
  logic    pop;

  assign cfg_ready = 1'b1;
  assign qctl.push = push;
  assign qctl.pop  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_low  <= RAW_BITS'(0);
      cfg.x_high <= RAW_BITS'(4095);
      cfg.y_low  <= RAW_BITS'(0);
      cfg.y_high <= RAW_BITS'(4095);
      cfg.width  <= POS_BITS'(320);
      cfg.height <= POS_BITS'(240);
      cfg.swap   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_LOW:  cfg.x_low  <= cfg_data[RAW_BITS-1:0];
        REG_X_HIGH: cfg.x_high <= cfg_data[RAW_BITS-1:0];
        REG_Y_LOW:  cfg.y_low  <= cfg_data[RAW_BITS-1:0];
        REG_Y_HIGH: cfg.y_high <= cfg_data[RAW_BITS-1:0];
        REG_WIDTH:  cfg.width  <= cfg_data[POS_BITS-1:0];
        REG_HEIGHT: cfg.height <= cfg_data[POS_BITS-1:0];
        REG_SWAP:   cfg.swap   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tec_front u_front (
    .evt       (evt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .qstat     (qstat),
    .push      (push),
    .cmd       (front_cmd)
  );

  tec_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .qctl   (qctl),
    .wr_cmd (front_cmd),
    .qstat  (qstat),
    .rd_cmd (head_cmd)
  );

  tec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .smp       (smp)
  );

endmodule

// File: rtl/tec_checker.sv
// port-level checks of the touch event calibrator, bound to the top level
// depends on tec_pkg and touch_event_calibrator_core_defines.svh
module tec_checker (
  input logic               clk,
  input logic               rst,
  input logic               evt_stall,
  input logic               smp_valid,
  input logic               smp_stall,
  input tec_pkg::smp_word_t smp,
  input logic               cfg_ready
);
  `include "touch_event_calibrator_core_defines.svh"

  `TEC_ASSERT_NXT(a_smp_hold, clk, rst, smp_valid && smp_stall, smp_valid, "word dropped")
  `TEC_ASSERT_NXT(a_smp_stable, clk, rst, smp_valid && smp_stall, $stable(smp), "word changed")
  `TEC_ASSERT_NXT(a_rst_empty, clk, 1'b0, rst, !smp_valid && !evt_stall, "not empty after reset")
  `TEC_ASSERT_NOW(a_cfg_ready, clk, rst, 1'b1, cfg_ready, "register port not ready")

endmodule

bind touch_event_calibrator_core tec_checker u_tec_checker (
  .clk       (clk),
  .rst       (rst),
  .evt_stall (evt_stall),
  .smp_valid (smp_valid),
  .smp_stall (smp_stall),
  .smp       (smp),
  .cfg_ready (cfg_ready)
);
